// File: hdl/zcns_pkg.sv
// Shared types and codes for the zone containment and nearest-centre search block.
package zcns_pkg;

   localparam int COORD_W = 12;
   localparam int POINT_W = 13;
   localparam int LEFT_W  = 14;
   localparam int DIFF_W  = 16;
   localparam int SQ_W    = 30;
   localparam int DSQ_W   = 31;
   localparam int DIST_W  = 36;
   localparam int ZIDX_W  = 7;
   localparam int HELD_W  = 8;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [11:0] FIELD_LENGTH_RESET = 12'd3000;

   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_ADD   = 2'd1;

   localparam logic [2:0] STATUS_ADDED    = 3'd0;
   localparam logic [2:0] STATUS_FULL     = 3'd1;
   localparam logic [2:0] STATUS_BAD_SIZE = 3'd2;
   localparam logic [2:0] STATUS_INSIDE   = 3'd3;
   localparam logic [2:0] STATUS_NEAREST  = 3'd4;
   localparam logic [2:0] STATUS_EMPTY    = 3'd5;

   localparam logic CSR_MIRROR = 1'b0;
   localparam logic CSR_FIELD  = 1'b1;

   typedef struct packed {
      logic signed [LEFT_W-1:0] left;
      logic [COORD_W-1:0]       bottom;
      logic [COORD_W-1:0]       span_x;
      logic [COORD_W-1:0]       span_y;
   } zone_type;

   typedef struct packed {
      logic             valid;
      logic             hit;
      logic [DSQ_W-1:0] dist_sq;
   } eval_type;

endpackage

// File: hdl/zone_containment_nearest_search.sv
// Top level: zone table, scan sequencer, configuration registers and result register.
//
//  Channel | Direction | Transfer contents
//  req     | in        | tuser: req_type; tdata: zone fields and query point
//  rsp     | out       | tuser: status; tdata: zone_index, distance_sq, zones_held
//  csr     | in/out    | mirror_enable at 0x0, field_length at 0x4
//
// Clear and add items are answered directly from the idle state. A query on a table of N zones
// scans it: one zone table read per cycle feeds the evaluation pipeline, which then drains.
// Reset is synchronous and empties the table; it needs no clearing pass.
// A new item is taken only while the sequencer is idle and the result register is free
// or being emptied in the same cycle; a stalled result holds a finished query.
module zone_containment_nearest_search
   import zcns_pkg::*;
#(
   parameter int MAX_ZONES = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // [11:0] zone_left, [23:12] zone_bottom, [35:24] zone_span_x, [47:36] zone_span_y,
   // [60:48] point_x, [73:61] point_y, [79:74] zero
   input  logic [79:0]       req_tdata,
   // [1:0] req_type
   input  logic [1:0]        req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // [6:0] zone_index, [42:7] distance_sq, [50:43] zones_held, [55:51] zero
   output logic [55:0]       rsp_tdata,
   // [2:0] status
   output logic [2:0]        rsp_tuser,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int IDX_W = $clog2(MAX_ZONES);
   localparam int CNT_W = $clog2(MAX_ZONES + 1);
   localparam logic [1:0] DRAIN_LAST = 2'd2;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_FINISH} state_type;

   logic [COORD_W-1:0]       zone_left, zone_bottom, zone_span_x, zone_span_y;
   logic signed [POINT_W-1:0] point_x, point_y;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          total_ff, total_in;
   logic [CNT_W-1:0]          scan_ff, scan_in;
   logic [1:0]                drain_ff, drain_in;
   logic signed [POINT_W-1:0] px_ff, px_in, py_ff, py_in;
   logic                      have_ff, have_in, found_ff, found_in;
   logic [IDX_W-1:0]          best_idx_ff, best_idx_in, found_idx_ff, found_idx_in;
   logic [DSQ_W-1:0]          best_d_ff, best_d_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [2:0]                rsp_status_ff, rsp_status_in;
   logic [ZIDX_W-1:0]         rsp_idx_ff, rsp_idx_in;
   logic [DIST_W-1:0]         rsp_dist_ff, rsp_dist_in;
   logic [HELD_W-1:0]         rsp_held_ff, rsp_held_in;
   logic                      mirror_ff;
   logic [COORD_W-1:0]        field_ff;

   logic                      req_fire, slot_free, issue, mem_we, csr_write;
   zone_type                  wr_zone, rd_data_ff;
   logic                      rd_valid_ff;
   logic [IDX_W-1:0]          rd_idx_ff;
   eval_type                  res;
   logic [IDX_W-1:0]          res_idx;

   zone_type zone_mem [MAX_ZONES];

   assign zone_left   = req_tdata[11:0];
   assign zone_bottom = req_tdata[23:12];
   assign zone_span_x = req_tdata[35:24];
   assign zone_span_y = req_tdata[47:36];
   assign point_x     = req_tdata[60:48];
   assign point_y     = req_tdata[73:61];

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire   = req_tvalid && req_tready;
   assign issue      = (state_ff == ST_SCAN);

   assign wr_zone.left = mirror_ff
      ? ({2'b00, field_ff} - {2'b00, zone_span_x} - {2'b00, zone_left})
      : {2'b00, zone_left};
   assign wr_zone.bottom = zone_bottom;
   assign wr_zone.span_x = zone_span_x;
   assign wr_zone.span_y = zone_span_y;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         zone_mem[total_ff[IDX_W-1:0]] <= wr_zone;
      end
      if (issue) begin
         rd_data_ff <= zone_mem[scan_ff[IDX_W-1:0]];
      end
      rd_idx_ff <= scan_ff[IDX_W-1:0];
   end

   zcns_zone_eval #(
      .IDX_W(IDX_W)
   ) u_eval (
      .clock    (clock),
      .reset    (reset),
      .ent_valid(rd_valid_ff),
      .ent_idx  (rd_idx_ff),
      .ent_zone (rd_data_ff),
      .point_x  (px_ff),
      .point_y  (py_ff),
      .res      (res),
      .res_idx  (res_idx)
   );

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      scan_in       = scan_ff;
      drain_in      = drain_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      have_in       = have_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      found_idx_in  = found_idx_ff;
      best_d_in     = best_d_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_held_in   = rsp_held_ff;
      mem_we        = 1'b0;

      if (res.valid) begin
         if (res.hit && !found_ff) begin
            found_in     = 1'b1;
            found_idx_in = res_idx;
         end
         if (!have_ff || (res.dist_sq < best_d_ff)) begin
            have_in     = 1'b1;
            best_d_in   = res.dist_sq;
            best_idx_in = res_idx;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = '0;
               rsp_dist_in  = '0;
               rsp_held_in  = HELD_W'(total_ff);
               case (req_tuser)
                  REQ_CLEAR: begin
                     total_in      = '0;
                     rsp_status_in = STATUS_ADDED;
                     rsp_held_in   = '0;
                  end
                  REQ_ADD: begin
                     if ((zone_span_x == '0) || (zone_span_y == '0)) begin
                        rsp_status_in = STATUS_BAD_SIZE;
                     end else if (total_ff == CNT_W'(MAX_ZONES)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        mem_we        = 1'b1;
                        total_in      = total_ff + CNT_W'(1);
                        rsp_status_in = STATUS_ADDED;
                        rsp_idx_in    = ZIDX_W'(total_ff);
                        rsp_held_in   = HELD_W'(total_in);
                     end
                  end
                  default: begin
                     if (total_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = rsp_valid_ff && !rsp_tready;
                        px_in        = point_x;
                        py_in        = point_y;
                        scan_in      = '0;
                        have_in      = 1'b0;
                        found_in     = 1'b0;
                        state_in     = ST_SCAN;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + CNT_W'(1);
            if (scan_ff == total_ff - CNT_W'(1)) begin
               drain_in = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + 2'd1;
            if (drain_ff == DRAIN_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_held_in  = HELD_W'(total_ff);
               if (found_ff) begin
                  rsp_status_in = STATUS_INSIDE;
                  rsp_idx_in    = ZIDX_W'(found_idx_ff);
                  rsp_dist_in   = '0;
               end else begin
                  rsp_status_in = STATUS_NEAREST;
                  rsp_idx_in    = ZIDX_W'(best_idx_ff);
                  rsp_dist_in   = DIST_W'(best_d_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         have_ff      <= 1'b0;
         found_ff     <= 1'b0;
         scan_ff      <= '0;
         drain_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= issue;
         have_ff      <= have_in;
         found_ff     <= found_in;
         scan_ff      <= scan_in;
         drain_ff     <= drain_in;
      end
      px_ff         <= px_in;
      py_ff         <= py_in;
      best_idx_ff   <= best_idx_in;
      found_idx_ff  <= found_idx_in;
      best_d_ff     <= best_d_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_held_ff   <= rsp_held_in;
   end

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_ff <= 1'b0;
         field_ff  <= FIELD_LENGTH_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_MIRROR: mirror_ff <= csr_pwdata[0];
            CSR_FIELD:  field_ff  <= csr_pwdata[COORD_W-1:0];
            default:    mirror_ff <= mirror_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_MIRROR: csr_prdata = {{(CSR_DW-1){1'b0}}, mirror_ff};
         CSR_FIELD:  csr_prdata = {{(CSR_DW-COORD_W){1'b0}}, field_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {5'b00000, rsp_held_ff, rsp_dist_ff, rsp_idx_ff};

endmodule

// File: hdl/zcns_zone_eval.sv
// Pipelined zone evaluator: containment test and squared doubled-centre distance.
module zcns_zone_eval
   import zcns_pkg::*;
#(
   parameter int IDX_W = 7
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      ent_valid,
   input  logic [IDX_W-1:0]          ent_idx,
   input  zone_type                  ent_zone,
   input  logic signed [POINT_W-1:0] point_x,
   input  logic signed [POINT_W-1:0] point_y,
   output eval_type                  res,
   output logic [IDX_W-1:0]          res_idx
);

   logic signed [LEFT_W:0]   l15, b15, r15, t15, px15, py15;
   logic signed [DIFF_W-1:0] lx2, by2, sx16, sy16, px2, py2, dx, dy;
   logic                     contained;
   logic signed [31:0]       prod_x, prod_y;

   logic                     s1_valid_ff, s1_hit_ff;
   logic signed [DIFF_W-1:0] s1_dx_ff, s1_dy_ff;
   logic [IDX_W-1:0]         s1_idx_ff;
   logic                     s2_valid_ff, s2_hit_ff;
   logic [SQ_W-1:0]          s2_sqx_ff, s2_sqy_ff;
   logic [IDX_W-1:0]         s2_idx_ff;

   always_comb begin
      l15  = {ent_zone.left[LEFT_W-1], ent_zone.left};
      b15  = {3'b000, ent_zone.bottom};
      r15  = l15 + {3'b000, ent_zone.span_x};
      t15  = b15 + {3'b000, ent_zone.span_y};
      px15 = {{2{point_x[POINT_W-1]}}, point_x};
      py15 = {{2{point_y[POINT_W-1]}}, point_y};
      contained = (l15 < px15) && (b15 < py15) && (r15 > px15) && (t15 > py15);

      lx2  = {ent_zone.left[LEFT_W-1], ent_zone.left, 1'b0};
      by2  = {3'b000, ent_zone.bottom, 1'b0};
      sx16 = {4'b0000, ent_zone.span_x};
      sy16 = {4'b0000, ent_zone.span_y};
      px2  = {{2{point_x[POINT_W-1]}}, point_x, 1'b0};
      py2  = {{2{point_y[POINT_W-1]}}, point_y, 1'b0};
      dx   = lx2 + sx16 - px2;
      dy   = by2 + sy16 - py2;
   end

   assign prod_x = s1_dx_ff * s1_dx_ff;
   assign prod_y = s1_dy_ff * s1_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= ent_valid;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_hit_ff    <= contained;
      s1_dx_ff     <= dx;
      s1_dy_ff     <= dy;
      s1_idx_ff    <= ent_idx;
      s2_hit_ff    <= s1_hit_ff;
      s2_sqx_ff    <= prod_x[SQ_W-1:0];
      s2_sqy_ff    <= prod_y[SQ_W-1:0];
      s2_idx_ff    <= s1_idx_ff;
   end

   assign res.valid   = s2_valid_ff;
   assign res.hit     = s2_hit_ff;
   assign res.dist_sq = {1'b0, s2_sqx_ff} + {1'b0, s2_sqy_ff};
   assign res_idx     = s2_idx_ff;

endmodule

// File: tb/sv/zcns_tb_pkg.sv
// Register addresses shared by the zone search testbench modules.
`timescale 1ns / 1ps
package zcns_tb_pkg;

   import zcns_pkg::*;

   localparam logic [CSR_AW-1:0] CSR_ADDR_MIRROR = {CSR_MIRROR, 2'b00};
   localparam logic [CSR_AW-1:0] CSR_ADDR_FIELD  = {CSR_FIELD, 2'b00};

endpackage

// File: tb/sv/zcns_answer_checker.sv
// Channel monitor that predicts zone search answers and compares them with the block output.
`timescale 1ns / 1ps
module zcns_answer_checker
   import zcns_pkg::*;
   import zcns_tb_pkg::*;
#(
   parameter int ZONE_SLOTS = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [79:0]       req_tdata,
   input  logic [1:0]        req_tuser,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [55:0]       rsp_tdata,
   input  logic [2:0]        rsp_tuser,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   input  logic              csr_pready,
   output int                fail_count,
   output int                answers_owed
);

   typedef struct packed {
      logic [2:0]        status;
      logic [ZIDX_W-1:0] zone_idx;
      logic [DIST_W-1:0] dist_sq;
      logic [HELD_W-1:0] held;
   } answer_type;

   logic signed [LEFT_W-1:0] left_edge   [ZONE_SLOTS];
   logic [COORD_W-1:0]       bottom_edge [ZONE_SLOTS];
   logic [COORD_W-1:0]       span_x      [ZONE_SLOTS];
   logic [COORD_W-1:0]       span_y      [ZONE_SLOTS];
   int                       zone_count;
   logic                     mirror_on;
   logic [COORD_W-1:0]       field_len;
   answer_type               owed_answers [$];
   answer_type               oldest;
   answer_type               seen;

   initial begin
      fail_count   = 0;
      answers_owed = 0;
      zone_count   = 0;
      mirror_on    = 1'b0;
      field_len    = FIELD_LENGTH_RESET;
   end

   function automatic answer_type predict_zone_answer(input logic [1:0] kind,
                                                      input logic [79:0] data);
      logic [COORD_W-1:0]       zl;
      logic [COORD_W-1:0]       zb;
      logic [COORD_W-1:0]       sx;
      logic [COORD_W-1:0]       sy;
      logic signed [POINT_W-1:0] px;
      logic signed [POINT_W-1:0] py;
      int                       px_i;
      int                       py_i;
      int                       l;
      int                       b;
      int                       i;
      int                       best;
      bit                       found;
      longint                   dx;
      longint                   dy;
      longint                   d;
      longint                   best_d;
      answer_type               a;
      zl = data[11:0];
      zb = data[23:12];
      sx = data[35:24];
      sy = data[47:36];
      px = data[60:48];
      py = data[73:61];
      px_i = int'(px);
      py_i = int'(py);
      a = '0;
      found = 1'b0;
      if (kind == REQ_CLEAR) begin
         zone_count = 0;
         a.status = STATUS_ADDED;
      end else if (kind == REQ_ADD) begin
         if (sx == 0 || sy == 0) begin
            a.status = STATUS_BAD_SIZE;
         end else if (zone_count >= ZONE_SLOTS) begin
            a.status = STATUS_FULL;
         end else begin
            l = mirror_on ? int'(field_len) - int'(sx) - int'(zl) : int'(zl);
            left_edge[zone_count]   = l[LEFT_W-1:0];
            bottom_edge[zone_count] = zb;
            span_x[zone_count]      = sx;
            span_y[zone_count]      = sy;
            a.status   = STATUS_ADDED;
            a.zone_idx = zone_count[ZIDX_W-1:0];
            zone_count++;
         end
      end else if (zone_count == 0) begin
         a.status = STATUS_EMPTY;
      end else begin
         for (i = 0; i < zone_count && !found; i++) begin
            l = int'(left_edge[i]);
            b = int'(bottom_edge[i]);
            if (l < px_i && b < py_i && l + int'(span_x[i]) > px_i &&
                b + int'(span_y[i]) > py_i) begin
               found      = 1'b1;
               a.status   = STATUS_INSIDE;
               a.zone_idx = i[ZIDX_W-1:0];
            end
         end
         if (!found) begin
            best   = 0;
            best_d = 0;
            for (i = 0; i < zone_count; i++) begin
               dx = longint'(2 * int'(left_edge[i]) + int'(span_x[i])) - 2 * longint'(px_i);
               dy = longint'(2 * int'(bottom_edge[i]) + int'(span_y[i])) - 2 * longint'(py_i);
               d  = dx * dx + dy * dy;
               if (i == 0 || d < best_d) begin
                  best   = i;
                  best_d = d;
               end
            end
            a.status   = STATUS_NEAREST;
            a.zone_idx = best[ZIDX_W-1:0];
            a.dist_sq  = best_d[DIST_W-1:0];
         end
      end
      a.held = zone_count[HELD_W-1:0];
      return a;
   endfunction

   task automatic check_field(input string what, input logic [DIST_W-1:0] want,
                              input logic [DIST_W-1:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         zone_count = 0;
         mirror_on  = 1'b0;
         field_len  = FIELD_LENGTH_RESET;
         owed_answers.delete();
      end else begin
         // A result transfer always belongs to an older request, so it is retired first.
         if (rsp_tvalid && rsp_tready) begin
            seen.status   = rsp_tuser;
            seen.zone_idx = rsp_tdata[6:0];
            seen.dist_sq  = rsp_tdata[42:7];
            seen.held     = rsp_tdata[50:43];
            if (owed_answers.size() == 0) begin
               fail_count++;
               $display("%0t ns: unexpected result, expected none, actual status %0d index %0d",
                        $time, seen.status, seen.zone_idx);
            end else begin
               oldest = owed_answers.pop_front();
               check_field("status", DIST_W'(oldest.status), DIST_W'(seen.status));
               check_field("zone_index", DIST_W'(oldest.zone_idx), DIST_W'(seen.zone_idx));
               check_field("distance_sq", oldest.dist_sq, seen.dist_sq);
               check_field("zones_held", DIST_W'(oldest.held), DIST_W'(seen.held));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr)
               CSR_ADDR_MIRROR: mirror_on = csr_pwdata[0];
               CSR_ADDR_FIELD:  field_len = csr_pwdata[COORD_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            owed_answers.push_back(predict_zone_answer(req_tuser, req_tdata));
         end
      end
      answers_owed = owed_answers.size();
   end

endmodule

// File: tb/sv/tb_zone_containment_nearest_search.sv
// Top-level testbench: clock, reset, request and register stimulus, and the final verdict.
`timescale 1ns / 1ps
module tb_zone_containment_nearest_search;

   import zcns_pkg::*;
   import zcns_tb_pkg::*;

   localparam int         ZONE_SLOTS      = 128;
   localparam int         CYCLE_LIMIT     = 1_000_000;
   localparam int         SETTLE_CYCLES   = ZONE_SLOTS + 12;
   localparam int         ITEMS_PER_PHASE = 250;
   localparam logic [1:0] REQ_QUERY       = 2'd2;
   localparam logic [1:0] REQ_QUERY_ALT   = 2'd3;

   logic              clock;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   // [11:0] zone_left, [23:12] zone_bottom, [35:24] zone_span_x, [47:36] zone_span_y,
   // [60:48] point_x, [73:61] point_y, [79:74] zero
   logic [79:0]       req_tdata   = '0;
   // [1:0] req_type
   logic [1:0]        req_tuser   = '0;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   // [6:0] zone_index, [42:7] distance_sq, [50:43] zones_held, [55:51] zero
   logic [55:0]       rsp_tdata;
   // [2:0] status
   logic [2:0]        rsp_tuser;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   int                fail_count;
   int                answers_owed;
   int                cycle_count = 0;
   int                items_sent  = 0;
   int                idle_pct    = 0;
   int                stall_pct   = 0;
   logic              cfg_mirror  = 1'b0;
   logic [11:0]       cfg_field   = FIELD_LENGTH_RESET;
   logic [11:0]       last_left   = 12'd1;
   logic [11:0]       last_bottom = 12'd1;
   logic [11:0]       last_span_x = 12'd1;
   logic [11:0]       last_span_y = 12'd1;

   zone_containment_nearest_search #(.MAX_ZONES(ZONE_SLOTS)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   zcns_answer_checker #(.ZONE_SLOTS(ZONE_SLOTS)) answer_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_pready   (csr_pready),
      .fail_count   (fail_count),
      .answers_owed (answers_owed)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic present_request(input logic [1:0] kind, input logic [11:0] zl,
                                  input logic [11:0] zb, input logic [11:0] sx,
                                  input logic [11:0] sy, input logic [12:0] px,
                                  input logic [12:0] py);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= {6'b0, py, px, sy, sx, zb, zl};
      req_tuser  <= kind;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (answers_owed != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure_phase(input logic mirror, input logic [11:0] field,
                                  input int sender_idle, input int receiver_stall);
      settle_idle();
      write_register(CSR_ADDR_MIRROR, CSR_DW'(mirror));
      write_register(CSR_ADDR_FIELD, CSR_DW'(field));
      cfg_mirror = mirror;
      cfg_field  = field;
      idle_pct   = sender_idle;
      stall_pct  = receiver_stall;
   endtask

   task automatic add_random_zone();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) begin
         last_left   = 12'($urandom);
         last_bottom = 12'($urandom);
         last_span_x = 12'($urandom_range(4095, 1));
         last_span_y = 12'($urandom_range(4095, 1));
      end else if (pick != 1) begin
         // A repeated zone (pick of one) gives equal centers and so nearest-search ties.
         last_left   = 12'($urandom_range(1000));
         last_bottom = 12'($urandom_range(1000));
         last_span_x = 12'($urandom_range(300, 1));
         last_span_y = 12'($urandom_range(300, 1));
      end
      present_request(REQ_ADD, last_left, last_bottom, last_span_x, last_span_y,
                      13'($urandom), 13'($urandom));
   endtask

   task automatic query_random_point();
      logic [1:0]  kind;
      logic [12:0] px;
      logic [12:0] py;
      int          base_x;
      kind = ($urandom_range(99) < 15) ? REQ_QUERY_ALT : REQ_QUERY;
      if ($urandom_range(99) < 40) begin
         px = 13'($urandom);
         py = 13'($urandom);
      end else begin
         base_x = int'($urandom_range(1150)) - 50;
         px = 13'(cfg_mirror ? int'(cfg_field) - base_x : base_x);
         py = 13'(int'($urandom_range(1150)) - 50);
      end
      present_request(kind, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                      px, py);
   endtask

   task automatic run_random_phase(input bit start_with_fill);
      int          goal;
      int          pick;
      int          adds;
      bit          fill;
      logic [11:0] sx;
      logic [11:0] sy;
      goal = items_sent + ITEMS_PER_PHASE;
      fill = start_with_fill;
      while (items_sent < goal) begin
         if (fill || $urandom_range(39) == 0) begin
            present_request(REQ_CLEAR, 12'($urandom), 12'($urandom), 12'($urandom),
                            12'($urandom), 13'($urandom), 13'($urandom));
            repeat (ZONE_SLOTS + 2) begin
               add_random_zone();
               if ($urandom_range(9) == 0) query_random_point();
            end
            present_request(REQ_ADD, 12'($urandom), 12'($urandom), 12'd0, 12'($urandom),
                            13'($urandom), 13'($urandom));
            query_random_point();
            fill = 1'b0;
         end else begin
            pick = $urandom_range(99);
            if (pick < 10) begin
               present_request(2'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                               12'($urandom), 13'($urandom), 13'($urandom));
            end else if (pick < 18) begin
               sx = 12'($urandom);
               sy = 12'($urandom);
               if ($urandom_range(1) == 0) begin
                  sx = 12'd0;
               end else begin
                  sy = 12'd0;
               end
               if ($urandom_range(3) == 0) begin
                  sx = 12'd0;
                  sy = 12'd0;
               end
               present_request(REQ_ADD, 12'($urandom), 12'($urandom), sx, sy,
                               13'($urandom), 13'($urandom));
            end else begin
               if ($urandom_range(3) == 0) begin
                  present_request(REQ_CLEAR, 12'($urandom), 12'($urandom), 12'($urandom),
                                  12'($urandom), 13'($urandom), 13'($urandom));
               end
               adds = $urandom_range(12, 1);
               repeat (adds) begin
                  add_random_zone();
                  if ($urandom_range(99) < 35) query_random_point();
               end
               repeat ($urandom_range(4, 1)) query_random_point();
            end
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      present_request(REQ_QUERY, 12'd0, 12'd0, 12'd0, 12'd0, 13'd0, 13'd0);
      present_request(REQ_QUERY_ALT, 12'd0, 12'd0, 12'd0, 12'd0, 13'h1000, 13'h0FFF);
      present_request(REQ_ADD, 12'd10, 12'd10, 12'd0, 12'd5, 13'd0, 13'd0);
      present_request(REQ_ADD, 12'd10, 12'd10, 12'd5, 12'd0, 13'd0, 13'd0);
      present_request(REQ_ADD, 12'd100, 12'd100, 12'd200, 12'd200, 13'd0, 13'd0);
      present_request(REQ_ADD, 12'd0, 12'd0, 12'd4095, 12'd4095, 13'd0, 13'd0);
      present_request(REQ_ADD, 12'd4095, 12'd4095, 12'd1, 12'd1, 13'd0, 13'd0);
      present_request(REQ_ADD, 12'd100, 12'd100, 12'd200, 12'd200, 13'd0, 13'd0);
      present_request(REQ_QUERY, 12'd0, 12'd0, 12'd0, 12'd0, 13'd150, 13'd150);
      // A point on an edge of the first zone falls through to the enclosing second one.
      present_request(REQ_QUERY, 12'd0, 12'd0, 12'd0, 12'd0, 13'd100, 13'd150);
      present_request(REQ_QUERY, 12'd0, 12'd0, 12'd0, 12'd0, 13'h0FFF, 13'h0FFF);
      present_request(REQ_QUERY, 12'd0, 12'd0, 12'd0, 12'd0, 13'h1000, 13'h1000);
      present_request(REQ_QUERY_ALT, 12'd0, 12'd0, 12'd0, 12'd0, 13'h0FFF, 13'h1000);
      present_request(REQ_QUERY, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 13'h1000, 13'h0FFF);
      present_request(REQ_CLEAR, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 13'h1FFF, 13'h1FFF);
      present_request(REQ_QUERY, 12'd0, 12'd0, 12'd0, 12'd0, 13'd5, 13'd5);
      present_request(REQ_ADD, 12'd4095, 12'd0, 12'd4095, 12'd1, 13'd0, 13'd0);
      present_request(REQ_ADD, 12'd0, 12'd4095, 12'd1, 12'd4095, 13'd0, 13'd0);
      present_request(REQ_QUERY, 12'd0, 12'd0, 12'd0, 12'd0, 13'd2000, 13'd2000);
      present_request(REQ_QUERY, 12'd0, 12'd0, 12'd0, 12'd0, 13'd0, 13'd0);
      present_request(REQ_CLEAR, 12'd0, 12'd0, 12'd0, 12'd0, 13'd0, 13'd0);

      configure_phase(1'b1, 12'd3000, 62, 0);
      run_random_phase(1'b1);
      configure_phase(1'b1, 12'd0, 0, 62);
      run_random_phase(1'b0);
      configure_phase(1'b1, 12'd4095, 10, 10);
      run_random_phase(1'b0);
      configure_phase(1'b0, 12'($urandom), 0, 0);
      run_random_phase(1'b0);

      settle_idle();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
